/* design/prefixed_axis_command_parser_defines.svh */
// Assertion macros for the prefixed axis command parser checker.
// Needs signals named clk and arst_n in the scope of use.
`ifndef PREFIXED_AXIS_COMMAND_PARSER_DEFINES_SVH
`define PREFIXED_AXIS_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PACP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pacp: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PACP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pacp: next-cycle check failed");

`endif

/* design/pacp_pkg.sv */
// Constants shared by the prefixed axis command parser files.
// No dependencies.
package pacp_pkg;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 40;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END    = 1'd1;

	localparam logic [39:0] PREFIX_RESET = 40'h24_4150_303A;
	localparam logic [7:0]  END_RESET    = 8'h21;

	// parser phases
	localparam logic [1:0] PHASE_IDLE   = 2'd0;
	localparam logic [1:0] PHASE_PREFIX = 2'd1;
	localparam logic [1:0] PHASE_SIGN   = 2'd2;
	localparam logic [1:0] PHASE_VALUE  = 2'd3;

	localparam logic [2:0] PREFIX_LAST = 3'd4;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_X     = 8'h58;
	localparam logic [7:0] CHAR_Y     = 8'h59;
	localparam logic [7:0] CHAR_Z     = 8'h5A;

	localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

endpackage

/* design/pacp_if.sv */
// Channel interfaces of the prefixed axis command parser: byte in, axis out, config.
// Depends on pacp_pkg.
interface pacp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface pacp_axis_if;
	logic              valid;
	logic              ready;
	logic              axis;
	logic signed [31:0] axis_value;

	modport source (output valid, output axis, output axis_value, input ready);
	modport sink (input valid, input axis, input axis_value, output ready);
endinterface

interface pacp_cfg_if;
	import pacp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/prefixed_axis_command_parser.sv */
// Prefixed axis command parser: prefix match, signed decimal parse, axis results.
// An accepted byte is registered in byte_s1, and its result word in the output register.
// Throughput: one byte per cycle; the input register stalls only while a result
// word waits in the output register and the sink holds ready low.
// Reset (arst_n low, asynchronous): phase idle, accumulator cleared, registers
// back to prefix "$AP0:" and end character '!'. Config port is always ready.
module prefixed_axis_command_parser (
	input logic         clk,
	input logic         arst_n,
	pacp_byte_if.sink   rx,
	pacp_axis_if.source tx,
	pacp_cfg_if.sink    cfg
);
	import pacp_pkg::*;

	logic [39:0] prefix_q;
	logic [7:0]  end_char_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic [1:0]  phase_q;
	logic [2:0]  pos_q;
	logic [30:0] mag_q;
	logic        neg_q;

	logic        out_valid_q;
	logic        out_axis_q;
	logic [31:0] out_value_q;

	logic        go_s1;
	logic        out_free;
	logic [7:0]  pfx_char;
	logic        is_digit;
	logic        is_letter;
	logic [34:0] mag_ext;
	logic [34:0] prod;
	logic [30:0] mag_sat;
	logic [31:0] signed_val;
	logic [2:0]  pos_inc;

	logic [1:0]  phase_d;
	logic [2:0]  pos_d;
	logic [30:0] mag_d;
	logic        neg_d;
	logic        emit;

	assign out_free = !out_valid_q || tx.ready;
	assign go_s1    = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || go_s1;
	assign cfg.ready = 1'b1;

	assign tx.valid      = out_valid_q;
	assign tx.axis       = out_axis_q;
	assign tx.axis_value = out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q   <= PREFIX_RESET;
			end_char_q <= END_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PREFIX: prefix_q <= cfg.data;
				CFG_END: end_char_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (pos_q)
			3'd0: pfx_char = prefix_q[39:32];
			3'd1: pfx_char = prefix_q[31:24];
			3'd2: pfx_char = prefix_q[23:16];
			3'd3: pfx_char = prefix_q[15:8];
			3'd4: pfx_char = prefix_q[7:0];
			default: pfx_char = 8'h00;
		endcase
	end

	assign is_digit  = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign is_letter = (byte_s1 >= CHAR_A) && (byte_s1 <= CHAR_Z);

	// mag * 10 + digit as (mag << 3) + (mag << 1) + digit, then saturate
	assign mag_ext = {4'b0, mag_q};
	assign prod    = (mag_ext << 3) + (mag_ext << 1) + {31'b0, byte_s1[3:0]};
	assign mag_sat = (prod > {4'b0, MAG_MAX}) ? MAG_MAX : prod[30:0];

	// negative zero comes out as 0 by itself
	assign signed_val = neg_q ? (32'd0 - {1'b0, mag_q}) : {1'b0, mag_q};
	assign pos_inc    = pos_q + 3'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		mag_d   = mag_q;
		neg_d   = neg_q;
		emit    = 1'b0;
		case (phase_q)
			PHASE_IDLE: begin
				if (byte_s1 == prefix_q[39:32]) begin
					phase_d = PHASE_PREFIX;
					pos_d   = 3'd1;
				end
			end
			PHASE_PREFIX: begin
				if (pos_q <= PREFIX_LAST && byte_s1 == pfx_char) begin
					if (pos_q == PREFIX_LAST) begin
						phase_d = PHASE_SIGN;
						pos_d   = 3'd0;
						mag_d   = 31'd0;
						neg_d   = 1'b0;
					end else begin
						pos_d = pos_inc;
					end
				end else begin
					phase_d = PHASE_IDLE;
					pos_d   = 3'd0;
					mag_d   = 31'd0;
					neg_d   = 1'b0;
				end
			end
			PHASE_SIGN: begin
				phase_d = PHASE_VALUE;
				if (byte_s1 == CHAR_MINUS) begin
					neg_d = 1'b1;
				end else if (is_digit) begin
					mag_d = mag_sat;
				end else begin
					phase_d = PHASE_IDLE;
					pos_d   = 3'd0;
					mag_d   = 31'd0;
					neg_d   = 1'b0;
				end
			end
			default: begin
				// digit wins over the end character, which wins over letters
				if (is_digit) begin
					mag_d = mag_sat;
				end else if (byte_s1 == end_char_q || !is_letter) begin
					phase_d = PHASE_IDLE;
					pos_d   = 3'd0;
					mag_d   = 31'd0;
					neg_d   = 1'b0;
				end else begin
					emit    = (byte_s1 == CHAR_X) || (byte_s1 == CHAR_Y);
					phase_d = PHASE_SIGN;
					mag_d   = 31'd0;
					neg_d   = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			pos_q   <= 3'd0;
			mag_q   <= 31'd0;
			neg_q   <= 1'b0;
		end else if (go_s1) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			mag_q   <= mag_d;
			neg_q   <= neg_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			out_axis_q  <= (byte_s1 == CHAR_Y);
			out_value_q <= signed_val;
		end
	end

endmodule

/* design/pacp_checker.sv */
// Port-level checks for the prefixed axis command parser, bound to the top level.
// Depends on prefixed_axis_command_parser_defines.svh.
`include "prefixed_axis_command_parser_defines.svh"

module pacp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_axis,
	input logic [31:0] out_value,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	`PACP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_axis) && $stable(out_value))
	`PACP_ASSERT_SAME(a_no_min_int, out_valid, out_value != 32'h8000_0000)
	`PACP_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)
	`PACP_ASSERT_SAME(a_result_has_byte, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind prefixed_axis_command_parser pacp_checker u_pacp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (rx.valid),
	.in_ready  (rx.ready),
	.out_valid (tx.valid),
	.out_ready (tx.ready),
	.out_axis  (tx.axis),
	.out_value (tx.axis_value),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

/* dv/tb_prefixed_axis_command_parser.sv */
// Testbench for the prefixed axis command parser: random and directed command bytes,
// with a predictor in a small checker class that tracks the expected axis words.
// Depends on pacp_pkg, the pacp channel interfaces and the parser RTL.
module tb_prefixed_axis_command_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import pacp_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int BYTES_PER_PHASE = 95;

	typedef struct packed {
		logic               axis;
		logic signed [31:0] value;
	} axis_word_t;

	// predicts parser behaviour and holds the axis words still to come out
	class axis_cmd_checker;
		logic [39:0] prefix_reg;
		logic [7:0]  end_reg;
		logic [1:0]  phase;
		logic [2:0]  pos;
		logic [30:0] mag;
		logic        neg;
		axis_word_t  expected_words[$];
		int          errors;

		function new();
			prefix_reg = PREFIX_RESET;
			end_reg = END_RESET;
			errors = 0;
			drop_command();
		endfunction

		function void drop_command();
			phase = PHASE_IDLE;
			pos = 3'd0;
			mag = 31'd0;
			neg = 1'b0;
		endfunction

		function logic [7:0] prefix_char(int p);
			return prefix_reg[(int'(PREFIX_LAST) - p) * 8 +: 8];
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			if (idx == CFG_PREFIX) begin
				prefix_reg = d;
			end else begin
				end_reg = d[7:0];
			end
		endfunction

		task report_mismatch(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void value_byte(logic [7:0] b);
			longint unsigned grown;
			axis_word_t w;
			if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
				grown = 64'(mag) * 10 + 64'(b - CHAR_ZERO);
				mag = (grown > 64'(MAG_MAX)) ? MAG_MAX : grown[30:0];
			end else if (b == end_reg || b < CHAR_A || b > CHAR_Z) begin
				drop_command();
			end else begin
				// other letters close the value silently
				if (b == CHAR_X || b == CHAR_Y) begin
					w.axis = (b == CHAR_Y);
					w.value = neg ? 32'd0 - {1'b0, mag} : {1'b0, mag};
					expected_words.push_back(w);
				end
				phase = PHASE_SIGN;
				mag = 31'd0;
				neg = 1'b0;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			case (phase)
				PHASE_IDLE: begin
					if (b == prefix_char(0)) begin
						phase = PHASE_PREFIX;
						pos = 3'd1;
					end
				end
				PHASE_PREFIX: begin
					// a mismatching byte is not retried against the first character
					if (pos <= PREFIX_LAST && b == prefix_char(pos)) begin
						if (pos == PREFIX_LAST) begin
							drop_command();
							phase = PHASE_SIGN;
						end else begin
							pos = pos + 3'd1;
						end
					end else begin
						drop_command();
					end
				end
				PHASE_SIGN: begin
					phase = PHASE_VALUE;
					if (b == CHAR_MINUS) begin
						neg = 1'b1;
					end else if (b < CHAR_ZERO || b > CHAR_NINE) begin
						drop_command();
					end else begin
						value_byte(b);
					end
				end
				default: begin
					value_byte(b);
				end
			endcase
		endfunction

		task check_word(logic axis, logic signed [31:0] value);
			axis_word_t w;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word axis=%0d value=%0d", axis, value));
				return;
			end
			w = expected_words.pop_front();
			if (axis !== w.axis)
				report_mismatch($sformatf("axis %0d, expected %0d", axis, w.axis));
			if (value !== w.value)
				report_mismatch($sformatf("axis_value %0d, expected %0d", value, w.value));
		endtask

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int   sent = 0;
	int   idle_cycles = 0;

	axis_cmd_checker sb = new();

	pacp_byte_if rx_if ();
	pacp_axis_if tx_if ();
	pacp_cfg_if  cfg_if ();

	prefixed_axis_command_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if),
		.cfg    (cfg_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		sb.note_byte(b);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// mostly well-formed commands with random content, some corrupted, some noise
	task automatic send_command();
		int kind;
		int bad;
		int pick;
		int ndig;
		bit minus;
		if ($urandom_range(0, 15) == 0)
			calm = ~calm;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		end else begin
			bad = (kind < 20) ? $urandom_range(0, 4) : -1;
			for (int i = 0; i < 5; i++)
				send_byte(i == bad ? 8'($urandom) : sb.prefix_char(i));
			repeat ($urandom_range(1, 4)) begin
				minus = ($urandom_range(0, 3) == 0);
				if (minus)
					send_byte(CHAR_MINUS);
				pick = $urandom_range(0, 99);
				if (pick < 85)
					ndig = $urandom_range(minus ? 0 : 1, 4);
				else if (pick < 95)
					ndig = $urandom_range(5, 9);
				else
					ndig = $urandom_range(10, 12);
				repeat (ndig) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 19) == 0)
					send_byte(8'($urandom));
				pick = $urandom_range(0, 9);
				if (pick < 7)
					send_byte(pick[0] ? CHAR_X : CHAR_Y);
				else if (pick < 9)
					send_byte(CHAR_A + 8'($urandom_range(0, 25)));
				else
					send_byte(8'($urandom));
			end
			if ($urandom_range(0, 4) != 0)
				send_byte(sb.end_reg);
		end
	endtask

	task automatic run_random(input int quota);
		int start;
		start = sent;
		while (sent - start < quota) send_command();
	endtask

	// bytes that give no word may still be in flight once the queue is empty
	task automatic settle();
		rx_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [39:0] prefix, input logic [7:0] endc);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= CFG_PREFIX;
		cfg_if.data <= prefix;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		sb.set_reg(CFG_PREFIX, prefix);
		cfg_if.index <= CFG_END;
		cfg_if.data <= {32'd0, endc};
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		sb.set_reg(CFG_END, {32'd0, endc});
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		logic [39:0] p;
		logic [7:0]  e;
		arst_n <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= 8'd0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_PREFIX;
		cfg_if.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// repeated lead char, lone minus, negative zero, dropped letter, saturation
		send_text("$$");
		send_text("$AP0:-X-0X7Q9999999999Y!");
		run_random(BYTES_PER_PHASE);

		for (int ph = 0; ph < 7; ph++) begin
			settle();
			case (ph)
				0: begin
					for (int k = 0; k < 5; k++)
						p = {p[31:0], 8'($urandom_range(33, 126))};
					e = 8'($urandom_range(33, 126));
				end
				1: begin
					p = 40'h24_2424_2424;
					e = CHAR_X;
				end
				2: begin
					p = '0;
					e = 8'h00;
				end
				3: begin
					p = '1;
					e = 8'hFF;
				end
				4: begin
					p = PREFIX_RESET;
					e = CHAR_ZERO + 8'd5;
				end
				5: begin
					p = {32'($urandom), 8'($urandom)};
					e = CHAR_MINUS;
				end
				default: begin
					p = PREFIX_RESET;
					e = END_RESET;
				end
			endcase
			program_regs(p, e);
			run_random(BYTES_PER_PHASE);
		end

		rx_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result side: random stalls before each word
	initial begin
		int stall;
		tx_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				tx_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tx_if.ready <= 1'b1;
			@(posedge clk);
			while (!tx_if.valid) @(posedge clk);
			sb.check_word(tx_if.axis, tx_if.axis_value);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule

/* prefixed_axis_command_parser.f */
+incdir+design
design/pacp_pkg.sv
design/pacp_if.sv
design/prefixed_axis_command_parser.sv
design/pacp_checker.sv
dv/tb_prefixed_axis_command_parser.sv
